// ===== design/prq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int PRIO_BITS   = 8;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int OP_W     = 2;
  localparam int ID_W     = 5;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT       = 2'd0,
    OP_REMOVE_HEAD  = 2'd1,
    OP_REMOVE_ENTRY = 2'd2,
    OP_CLEAR        = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_DUP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COMPARE = 2'd1,
    S_APPLY   = 2'd2
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     removed_id;
    logic [ID_W-1:0]     head_id;
    logic                queue_empty;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic apply;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/prq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output prq_pkg::cmd_t      cmd
);

  prq_pkg::state_t state;
  prq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.apply   = 1'b0;
    unique case (state)
      prq_pkg::S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = prq_pkg::S_COMPARE;
        end
      end
      prq_pkg::S_COMPARE: begin
        busy        = 1'b1;
        cmd.compare = 1'b1;
        state_next  = prq_pkg::S_APPLY;
      end
      prq_pkg::S_APPLY: begin
        // The cells update at the end of this cycle, so the next transaction
        // can be captured at the same edge and compared in the following cycle.
        cmd.apply = 1'b1;
        cmd.load  = start;
        if (start) begin
          state_next = prq_pkg::S_COMPARE;
        end else begin
          state_next = prq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = prq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/prq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prq_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire prq_pkg::cmd_t   cmd,
  input  wire prq_pkg::req_t   req,
  output logic                 done,
  output prq_pkg::result_t     result
);

  localparam int MAX = prq_pkg::MAX_ENTRIES;

  prq_pkg::req_t req_q;

  logic [prq_pkg::ID_W-1:0]      cell_id   [MAX];
  logic [prq_pkg::PRIO_BITS-1:0] cell_prio [MAX];
  logic [prq_pkg::ID_W-1:0]      cell_id_next   [MAX];
  logic [prq_pkg::PRIO_BITS-1:0] cell_prio_next [MAX];

  logic [prq_pkg::CNT_W-1:0] occupancy;
  logic [2**prq_pkg::ID_W-1:0] queued_mask;

  // Compare stage results.
  logic [MAX-1:0] valid;
  logic [MAX-1:0] ge;
  logic [MAX-1:0] boundary;
  logic [MAX-1:0] hit;
  logic [MAX-1:0] sel;
  logic [prq_pkg::IDX_W-1:0] idx_next;
  logic [prq_pkg::IDX_W-1:0] idx;
  prq_pkg::status_t status_next;
  prq_pkg::status_t status_q;
  logic ok_next;
  logic ok;

  logic [prq_pkg::STATUS_W-1:0] status_r;
  logic [prq_pkg::ID_W-1:0]     removed_r;
  logic [prq_pkg::ID_W-1:0]     removed_next;
  logic [prq_pkg::ID_W-1:0]     clear_id;
  logic                         shift_cells;
  prq_pkg::op_t                 op;
  logic [prq_pkg::PRIO_BITS-1:0] new_prio;

  assign op       = prq_pkg::op_t'(req_q.operation);
  assign new_prio = req_q.priority_req[prq_pkg::PRIO_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // Every cell compares itself against the request in parallel. The queue is
  // sorted, so the cells that stay ahead of an insert form a prefix and the
  // insert point is the single cell just past the end of that prefix.
  always_comb begin
    for (int i = 0; i < MAX; i++) begin
      valid[i] = prq_pkg::CNT_W'(i) < occupancy;
      ge[i]    = valid[i] && (cell_prio[i] >= new_prio);
      hit[i]   = valid[i] && (cell_id[i] == req_q.entry_id);
    end
    boundary[0] = !ge[0];
    for (int i = 1; i < MAX; i++) begin
      boundary[i] = !ge[i] && ge[i-1];
    end
    sel = (op == prq_pkg::OP_INSERT) ? boundary : hit;
    if (op == prq_pkg::OP_REMOVE_HEAD) begin
      sel = '0;
    end
    idx_next = '0;
    for (int i = 0; i < MAX; i++) begin
      if (sel[i]) begin
        idx_next = idx_next | prq_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_next = prq_pkg::STAT_OK;
    ok_next     = 1'b1;
    case (op)
      prq_pkg::OP_INSERT: begin
        if (queued_mask[req_q.entry_id]) begin
          status_next = prq_pkg::STAT_DUP;
          ok_next     = 1'b0;
        end else if (occupancy == prq_pkg::CNT_W'(MAX)) begin
          status_next = prq_pkg::STAT_MISS;
          ok_next     = 1'b0;
        end
      end
      prq_pkg::OP_REMOVE_HEAD: begin
        if (occupancy == '0) begin
          status_next = prq_pkg::STAT_MISS;
          ok_next     = 1'b0;
        end
      end
      prq_pkg::OP_REMOVE_ENTRY: begin
        if (!queued_mask[req_q.entry_id]) begin
          status_next = prq_pkg::STAT_MISS;
          ok_next     = 1'b0;
        end
      end
      default: begin
        status_next = prq_pkg::STAT_OK;
        ok_next     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      idx      <= idx_next;
      status_q <= status_next;
      ok       <= ok_next;
    end
  end

  // Apply stage: cells past the index shift by one toward the tail on an
  // insert and toward the head on a remove.
  always_comb begin
    for (int i = 0; i < MAX; i++) begin
      cell_id_next[i]   = cell_id[i];
      cell_prio_next[i] = cell_prio[i];
      if (op == prq_pkg::OP_INSERT) begin
        if (prq_pkg::IDX_W'(i) == idx) begin
          cell_id_next[i]   = req_q.entry_id;
          cell_prio_next[i] = new_prio;
        end else if (i > 0 && prq_pkg::IDX_W'(i) > idx) begin
          cell_id_next[i]   = cell_id[(i > 0) ? i - 1 : 0];
          cell_prio_next[i] = cell_prio[(i > 0) ? i - 1 : 0];
        end
      end else if (i < MAX - 1 && prq_pkg::IDX_W'(i) >= idx) begin
        cell_id_next[i]   = cell_id[(i < MAX - 1) ? i + 1 : i];
        cell_prio_next[i] = cell_prio[(i < MAX - 1) ? i + 1 : i];
      end
    end
  end

  assign shift_cells = cmd.apply && ok && (op != prq_pkg::OP_CLEAR);
  assign clear_id    = (op == prq_pkg::OP_REMOVE_HEAD) ? cell_id[0] : req_q.entry_id;

  always_comb begin
    removed_next = '0;
    if (ok && (op == prq_pkg::OP_REMOVE_HEAD || op == prq_pkg::OP_REMOVE_ENTRY)) begin
      removed_next = clear_id;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_cells) begin
      for (int i = 0; i < MAX; i++) begin
        cell_id[i]   <= cell_id_next[i];
        cell_prio[i] <= cell_prio_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy   <= '0;
      queued_mask <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.apply;
      if (cmd.apply && ok) begin
        case (op) inside
          prq_pkg::OP_INSERT: begin
            occupancy               <= occupancy + 1'b1;
            queued_mask[clear_id]   <= 1'b1;
          end
          prq_pkg::OP_REMOVE_HEAD, prq_pkg::OP_REMOVE_ENTRY: begin
            occupancy               <= occupancy - 1'b1;
            queued_mask[clear_id]   <= 1'b0;
          end
          default: begin
            occupancy   <= '0;
            queued_mask <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_r  <= status_q;
      removed_r <= removed_next;
    end
  end

  // The cells only change at the end of an apply cycle, which never falls in
  // the strobe cycle, so the head and count read straight from the state.
  always_comb begin
    result.status      = status_r;
    result.removed_id  = removed_r;
    result.head_id     = (occupancy != '0) ? cell_id[0] : '0;
    result.queue_empty = (occupancy == '0);
    result.entry_count = prq_pkg::COUNT_W'(occupancy);
  end

endmodule

`default_nettype wire

// ===== design/priority_ready_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req    (prq_pkg::req_t)
// result    out        done high for one cycle   result (prq_pkg::result_t)
//
// A transaction first compares the request against every queue cell in
// parallel, then shifts the cells and updates the count.
// The result strobes in the cycle after the update; busy is high only in the
// compare cycle, so a new request can be accepted while the last is applied.
// Synchronous reset empties the queue; cell contents are not reset.
// The receiver cannot stall results.

module priority_ready_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire prq_pkg::req_t     req,
  output logic                   done,
  output prq_pkg::result_t       result
);

  prq_pkg::cmd_t cmd;

  prq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  prq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .done   (done),
    .result (result)
  );

  a_compare_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("compare stage held longer than one cycle");

  a_accept_to_compare: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not enter compare");

  a_done_after_compare: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy, 2))
    else $error("result strobe without a preceding compare");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result.entry_count <= 6'(prq_pkg::MAX_ENTRIES))
    else $error("entry count above capacity");

endmodule

`default_nettype wire
